[rtl/owpsc_pkg.sv]
// Package: types, constants and register indexes for the omni wheel speed controller.
`default_nettype none
package owpsc_pkg;
   localparam int WHEELS     = 3;
   localparam int DUTY_BITS  = 14;
   localparam int WIDX_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int ACC_W      = 64;

   localparam logic signed [17:0] ERR_MAX    = 18'sd131071;
   localparam logic signed [17:0] ERR_MIN    = -18'sd131072;
   localparam logic signed [23:0] INT_LIMIT  = 24'sd83886;
   localparam logic signed [31:0] PERIOD_Q24 = 32'sd167772;
   localparam logic signed [31:0] HALF_SQRT3 = 32'sd56756;
   localparam logic signed [15:0] ZERO_BAND  = 16'sd4;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_TARGET = 2'd1,
      ACT_BODY   = 2'd2,
      ACT_STOP   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_GAIN_P   = 3'd0,
      REG_GAIN_I   = 3'd1,
      REG_GAIN_D   = 3'd2,
      REG_SPP      = 3'd3,
      REG_MAX_SPD  = 3'd4,
      REG_DUTY_SCL = 3'd5,
      REG_REVERSED = 3'd6,
      REG_CENTRE   = 3'd7
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_STOP,
      ST_TGT,
      ST_B_ROT,
      ST_B_VY,
      ST_B_W0,
      ST_B_W1,
      ST_B_W2,
      ST_B_FILL,
      ST_T_SPEED,
      ST_T_ERR,
      ST_T_INC,
      ST_T_INT,
      ST_T_P,
      ST_T_I,
      ST_T_D,
      ST_T_EFF,
      ST_T_MAG,
      ST_T_DUTY,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [19:0] speed_per_pulse;
      logic [14:0] max_speed;
      logic [23:0] duty_scale;
      logic [WHEELS-1:0] wheel_reversed;
      logic [15:0] centre_to_wheel;
   } cfg_type;

   function automatic logic signed [ACC_W-1:0] round_shift(
      input logic signed [ACC_W-1:0] v, input int s);
      logic [ACC_W-1:0] m;
      begin
         m = v[ACC_W-1] ? (~v + 1'b1) : v;
         m = (m + (64'd1 << (s - 1))) >> s;
         round_shift = v[ACC_W-1] ? -$signed(m) : $signed(m);
      end
   endfunction

   function automatic logic signed [15:0] limit_speed(
      input logic signed [ACC_W-1:0] v, input logic [14:0] mx);
      logic signed [ACC_W-1:0] m;
      logic signed [ACC_W-1:0] n;
      begin
         m = $signed({{(ACC_W-15){1'b0}}, mx});
         n = -m;
         if (v > m)
            limit_speed = m[15:0];
         else if (v < n)
            limit_speed = n[15:0];
         else
            limit_speed = v[15:0];
      end
   endfunction
endpackage
`default_nettype wire

[rtl/owpsc_if.sv]
// Valid/ready channel interfaces for request and response transactions.
`default_nettype none
interface owpsc_req_if (input wire logic clock);
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [1:0]  wheel;
   logic signed [15:0] enc_pulses;
   logic signed [15:0] target_speed;
   logic signed [15:0] velocity_x;
   logic signed [15:0] velocity_y;
   logic signed [15:0] turn_rate;
   modport source (output valid, action, wheel, enc_pulses, target_speed, velocity_x,
                   velocity_y, turn_rate, input ready);
   modport sink (input valid, action, wheel, enc_pulses, target_speed, velocity_x,
                 velocity_y, turn_rate, output ready);
endinterface

interface owpsc_rsp_if (input wire logic clock);
   logic        valid;
   logic        ready;
   logic [1:0]  drive_wheel;
   logic [13:0] duty;
   logic        dir_a;
   logic        dir_b;
   modport source (output valid, drive_wheel, duty, dir_a, dir_b, input ready);
   modport sink (input valid, drive_wheel, duty, dir_a, dir_b, output ready);
endinterface
`default_nettype wire

[rtl/owpsc_mac.sv]
// Shared signed multiply-accumulate unit, one product per cycle.
`default_nettype none
module owpsc_mac (
   input  wire logic clock,
   input  wire logic clear,
   input  wire logic en,
   input  wire logic signed [31:0] op_a,
   input  wire logic signed [31:0] op_b,
   output logic signed [owpsc_pkg::ACC_W-1:0] acc
);
   logic signed [owpsc_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [63:0] prod;

   assign prod = op_a * op_b;

   always_comb begin
      acc_in = acc_ff;
      if (clear)
         acc_in = prod;
      else if (en)
         acc_in = acc_ff + prod;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

[rtl/omni_wheel_pid_speed_control.sv]
// Top level: omni wheel PID speed controller with sequencer and shared MAC.
// One transaction at a time. A control tick steps T_SPEED, T_ERR, T_INC, T_INT, T_P, T_I,
// T_D, T_EFF, T_MAG, T_DUTY, OUT (T_SPEED straight to OUT when the wheel's target lies in
// the zero band), set target TGT, body velocity B_ROT, B_VY, B_W0, B_W1, B_W2, B_FILL, stop
// STOP; each product step drives one product through the single 32x32 multiply-accumulate
// unit. No response is given for actions other than a control tick of a valid wheel.
// req.ready is low while a transaction is in work or a response waits to be taken.
`default_nettype none
module omni_wheel_pid_speed_control (
   input  wire logic clock,
   input  wire logic reset,
   owpsc_req_if.sink   req,
   owpsc_rsp_if.source rsp,
   input  wire logic csr_we,
   input  wire logic [owpsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [owpsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int W = owpsc_pkg::WHEELS;
   localparam int AW = owpsc_pkg::ACC_W;

   owpsc_pkg::cfg_type   cfg_ff, cfg_in;
   owpsc_pkg::state_type state_ff, state_in;

   logic signed [15:0] target_ff [W];
   logic signed [23:0] integ_ff [W];
   logic signed [17:0] perr_ff [W];
   logic signed [15:0] target_in [W];
   logic signed [23:0] integ_in [W];
   logic signed [17:0] perr_in [W];

   logic [1:0]  wh_ff, wh_in;
   logic signed [15:0] pc_ff, pc_in, tv_ff, tv_in, vx_ff, vx_in, vy_ff, vy_in, om_ff, om_in;
   logic signed [17:0] err_ff, err_in;
   logic signed [AW-1:0] tmp_ff, tmp_in, rot_ff, rot_in;
   logic signed [15:0] eff_ff, eff_in;
   logic [1:0]  owheel_ff, owheel_in;
   logic [13:0] duty_ff, duty_in;
   logic        da_ff, da_in, db_ff, db_in;

   logic mac_clear, mac_en;
   logic signed [31:0] mac_a, mac_b;
   logic signed [AW-1:0] acc;

   owpsc_mac u_mac (
      .clock(clock), .clear(mac_clear), .en(mac_en),
      .op_a(mac_a), .op_b(mac_b), .acc(acc)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (owpsc_pkg::reg_index_type'(csr_index))
            owpsc_pkg::REG_GAIN_P:   cfg_in.gain_p = csr_wdata[15:0];
            owpsc_pkg::REG_GAIN_I:   cfg_in.gain_i = csr_wdata[15:0];
            owpsc_pkg::REG_GAIN_D:   cfg_in.gain_d = csr_wdata[15:0];
            owpsc_pkg::REG_SPP:      cfg_in.speed_per_pulse = csr_wdata[19:0];
            owpsc_pkg::REG_MAX_SPD:  cfg_in.max_speed = csr_wdata[14:0];
            owpsc_pkg::REG_DUTY_SCL: cfg_in.duty_scale = csr_wdata[23:0];
            owpsc_pkg::REG_REVERSED: cfg_in.wheel_reversed = csr_wdata[W-1:0];
            owpsc_pkg::REG_CENTRE:   cfg_in.centre_to_wheel = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic rev;
   logic signed [15:0] t_cur;
   logic signed [AW-1:0] rs, rs16, e64, ilim, isum;
   logic [AW-1:0] dmag;
   logic signed [15:0] eff_c, bt;
   logic pos;

   assign rev   = cfg_ff.wheel_reversed[wh_ff];
   assign t_cur = target_ff[wh_ff];
   assign rs16  = owpsc_pkg::round_shift(acc, 16);

   always_comb begin
      state_in = state_ff;
      wh_in = wh_ff; pc_in = pc_ff; tv_in = tv_ff;
      vx_in = vx_ff; vy_in = vy_ff; om_in = om_ff;
      err_in = err_ff; tmp_in = tmp_ff; rot_in = rot_ff; eff_in = eff_ff;
      owheel_in = owheel_ff; duty_in = duty_ff; da_in = da_ff; db_in = db_ff;
      target_in = target_ff; integ_in = integ_ff; perr_in = perr_ff;
      mac_clear = 1'b0; mac_en = 1'b0; mac_a = '0; mac_b = '0;
      req.ready = 1'b0; rsp.valid = 1'b0;
      rs = '0; e64 = '0; ilim = '0; isum = '0; dmag = '0; eff_c = '0; bt = '0; pos = 1'b0;
      case (state_ff)
         owpsc_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               wh_in = req.wheel; pc_in = req.enc_pulses;
               tv_in = req.target_speed; vx_in = req.velocity_x;
               vy_in = req.velocity_y; om_in = req.turn_rate;
               case (owpsc_pkg::action_type'(req.action))
                  owpsc_pkg::ACT_STOP:   state_in = owpsc_pkg::ST_STOP;
                  owpsc_pkg::ACT_TARGET: state_in = owpsc_pkg::ST_TGT;
                  owpsc_pkg::ACT_BODY:   state_in = owpsc_pkg::ST_B_ROT;
                  default: state_in = (req.wheel < 2'(W)) ? owpsc_pkg::ST_T_SPEED
                                                            : owpsc_pkg::ST_IDLE;
               endcase
            end
         end
         owpsc_pkg::ST_STOP: begin
            for (int i = 0; i < W; i++) begin
               target_in[i] = '0; integ_in[i] = '0; perr_in[i] = '0;
            end
            state_in = owpsc_pkg::ST_IDLE;
         end
         owpsc_pkg::ST_TGT: begin
            if (wh_ff < 2'(W))
               target_in[wh_ff] = owpsc_pkg::limit_speed(AW'(tv_ff), cfg_ff.max_speed);
            state_in = owpsc_pkg::ST_IDLE;
         end
         owpsc_pkg::ST_B_ROT: begin
            mac_clear = 1'b1;
            mac_a = {16'd0, cfg_ff.centre_to_wheel};
            mac_b = 32'(om_ff);
            state_in = owpsc_pkg::ST_B_VY;
         end
         owpsc_pkg::ST_B_VY: begin
            rot_in = acc <<< 2;
            mac_clear = 1'b1;
            mac_a = 32'(vy_ff);
            mac_b = owpsc_pkg::HALF_SQRT3;
            state_in = owpsc_pkg::ST_B_W0;
         end
         owpsc_pkg::ST_B_W0: begin
            tmp_in = acc;
            rs = owpsc_pkg::round_shift((AW'(vx_ff) <<< 15) - acc - rot_ff, 16);
            bt = owpsc_pkg::limit_speed(rs, cfg_ff.max_speed);
            target_in[0] = bt;
            state_in = owpsc_pkg::ST_B_W1;
         end
         owpsc_pkg::ST_B_W1: begin
            rs = owpsc_pkg::round_shift((AW'(vx_ff) <<< 16) + rot_ff, 16);
            bt = owpsc_pkg::limit_speed(rs, cfg_ff.max_speed);
            if (W > 1) target_in[1 % W] = bt;
            state_in = owpsc_pkg::ST_B_W2;
         end
         owpsc_pkg::ST_B_W2: begin
            rs = owpsc_pkg::round_shift((AW'(vx_ff) <<< 15) + tmp_ff - rot_ff, 16);
            bt = owpsc_pkg::limit_speed(rs, cfg_ff.max_speed);
            if (W > 2) target_in[2 % W] = bt;
            state_in = owpsc_pkg::ST_B_FILL;
         end
         owpsc_pkg::ST_B_FILL: begin
            for (int i = 3; i < W; i++) target_in[i] = '0;
            state_in = owpsc_pkg::ST_IDLE;
         end
         owpsc_pkg::ST_T_SPEED: begin
            owheel_in = wh_ff;
            if (t_cur >= -owpsc_pkg::ZERO_BAND && t_cur <= owpsc_pkg::ZERO_BAND) begin
               integ_in[wh_ff] = '0; perr_in[wh_ff] = '0;
               duty_in = '0; da_in = 1'b0; db_in = 1'b0;
               state_in = owpsc_pkg::ST_OUT;
            end else begin
               mac_clear = 1'b1;
               mac_a = 32'(pc_ff);
               mac_b = {12'd0, cfg_ff.speed_per_pulse};
               state_in = owpsc_pkg::ST_T_ERR;
            end
         end
         owpsc_pkg::ST_T_ERR: begin
            rs = owpsc_pkg::round_shift(rev ? -acc : acc, 4);
            e64 = AW'(t_cur) - rs;
            if (e64 > AW'(owpsc_pkg::ERR_MAX)) err_in = owpsc_pkg::ERR_MAX;
            else if (e64 < AW'(owpsc_pkg::ERR_MIN)) err_in = owpsc_pkg::ERR_MIN;
            else err_in = e64[17:0];
            state_in = owpsc_pkg::ST_T_INC;
         end
         owpsc_pkg::ST_T_INC: begin
            mac_clear = 1'b1;
            mac_a = 32'(err_ff);
            mac_b = owpsc_pkg::PERIOD_Q24;
            state_in = owpsc_pkg::ST_T_INT;
         end
         owpsc_pkg::ST_T_INT: begin
            isum = AW'(integ_ff[wh_ff]) + rs16;
            ilim = AW'(owpsc_pkg::INT_LIMIT);
            if (isum > ilim) integ_in[wh_ff] = owpsc_pkg::INT_LIMIT;
            else if (isum < -ilim) integ_in[wh_ff] = -owpsc_pkg::INT_LIMIT;
            else integ_in[wh_ff] = isum[23:0];
            tmp_in = 64'(err_ff - perr_ff[wh_ff]) * 100;
            perr_in[wh_ff] = err_ff;
            state_in = owpsc_pkg::ST_T_P;
         end
         owpsc_pkg::ST_T_P: begin
            mac_clear = 1'b1;
            mac_a = {16'd0, cfg_ff.gain_p};
            mac_b = 32'(err_ff) <<< 8;
            state_in = owpsc_pkg::ST_T_I;
         end
         owpsc_pkg::ST_T_I: begin
            mac_en = 1'b1;
            mac_a = {16'd0, cfg_ff.gain_i};
            mac_b = 32'(integ_ff[wh_ff]);
            state_in = owpsc_pkg::ST_T_D;
         end
         owpsc_pkg::ST_T_D: begin
            // derivative times 2^8 can exceed 32 bits, so the scale goes on the gain
            mac_en = 1'b1;
            mac_a = {8'd0, cfg_ff.gain_d, 8'd0};
            mac_b = tmp_ff[31:0];
            state_in = owpsc_pkg::ST_T_EFF;
         end
         owpsc_pkg::ST_T_EFF: begin
            rs = owpsc_pkg::round_shift(acc + (AW'(t_cur) <<< 16), 16);
            if ((t_cur > owpsc_pkg::ZERO_BAND && rs < 0) ||
                (t_cur < -owpsc_pkg::ZERO_BAND && rs > 0))
               rs = '0;
            eff_c = owpsc_pkg::limit_speed(rs, cfg_ff.max_speed);
            eff_in = eff_c;
            state_in = owpsc_pkg::ST_T_MAG;
         end
         owpsc_pkg::ST_T_MAG: begin
            mac_clear = 1'b1;
            mac_a = 32'(eff_ff < 0 ? -eff_ff : eff_ff);
            mac_b = {8'd0, cfg_ff.duty_scale};
            state_in = owpsc_pkg::ST_T_DUTY;
         end
         owpsc_pkg::ST_T_DUTY: begin
            dmag = (acc + 64'd524288) >> 20;
            duty_in = (dmag > 64'(2**owpsc_pkg::DUTY_BITS - 1))
                      ? 14'(2**owpsc_pkg::DUTY_BITS - 1) : dmag[13:0];
            pos = (eff_ff > 0) != rev;
            if (eff_ff == 0) begin
               duty_in = '0; da_in = 1'b0; db_in = 1'b0;
            end else begin
               da_in = pos; db_in = !pos;
            end
            state_in = owpsc_pkg::ST_OUT;
         end
         owpsc_pkg::ST_OUT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) state_in = owpsc_pkg::ST_IDLE;
         end
         default: state_in = owpsc_pkg::ST_IDLE;
      endcase
   end

   assign rsp.drive_wheel = owheel_ff;
   assign rsp.duty  = duty_ff;
   assign rsp.dir_a = da_ff;
   assign rsp.dir_b = db_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= owpsc_pkg::ST_IDLE;
         cfg_ff <= '{gain_p: 16'd256, gain_i: '0, gain_d: '0, speed_per_pulse: '0,
                     max_speed: 15'd4096, duty_scale: '0, wheel_reversed: '0,
                     centre_to_wheel: '0};
         for (int i = 0; i < W; i++) begin
            target_ff[i] <= '0; integ_ff[i] <= '0; perr_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cfg_ff <= cfg_in;
         target_ff <= target_in; integ_ff <= integ_in; perr_ff <= perr_in;
      end
      wh_ff <= wh_in; pc_ff <= pc_in; tv_ff <= tv_in;
      vx_ff <= vx_in; vy_ff <= vy_in; om_ff <= om_in;
      err_ff <= err_in; tmp_ff <= tmp_in; rot_ff <= rot_in; eff_ff <= eff_in;
      owheel_ff <= owheel_in; duty_ff <= duty_in; da_ff <= da_in; db_ff <= db_in;
   end

   a_pins_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.dir_a && rsp.dir_b)) else $error("both direction pins set");
   a_zero_duty_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.dir_a && !rsp.dir_b) |-> rsp.duty == '0)
      else $error("duty without direction");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("ready while response pending");
   a_integ_limit: assert property (@(posedge clock) disable iff (reset)
      integ_ff[0] <= owpsc_pkg::INT_LIMIT && integ_ff[0] >= -owpsc_pkg::INT_LIMIT)
      else $error("integral out of range");
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Testbench for the omni wheel PID speed controller: predicted response scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   typedef struct packed {
      logic [1:0]         action;
      logic [1:0]         wheel;
      logic signed [15:0] enc_pulses;
      logic signed [15:0] target_speed;
      logic signed [15:0] velocity_x;
      logic signed [15:0] velocity_y;
      logic signed [15:0] turn_rate;
   } command_type;

   typedef struct packed {
      logic [1:0]  drive_wheel;
      logic [13:0] duty;
      logic        dir_a;
      logic        dir_b;
   } drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [owpsc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [owpsc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   owpsc_req_if req (clock);
   owpsc_rsp_if rsp (clock);

   omni_wheel_pid_speed_control dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // controller model state
   longint kp, ki, kd, spp, vmax, dscale, rev_mask, c2w;
   longint wheel_target [owpsc_pkg::WHEELS];
   longint wheel_integ [owpsc_pkg::WHEELS];
   longint wheel_prev_err [owpsc_pkg::WHEELS];

   command_type pending_commands[$];
   drive_type   expected_drives[$];
   int          errors = 0;
   int          stall_long = 0;
   bit          rsp_flood = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic longint rnd_away(longint v, int s);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic model_reset();
      kp = 256; ki = 0; kd = 0; spp = 0; vmax = 4096; dscale = 0; rev_mask = 0; c2w = 0;
      for (int i = 0; i < owpsc_pkg::WHEELS; i++) begin
         wheel_target[i] = 0; wheel_integ[i] = 0; wheel_prev_err[i] = 0;
      end
   endtask

   task automatic predict_drive(command_type c);
      longint t, spd, err, inc, integ, deriv, eff, mag, dty, rot, hx, vys;
      longint ws [3];
      bit rev, pos;
      drive_type d;
      int w;
      w = int'(c.wheel);
      case (owpsc_pkg::action_type'(c.action))
         owpsc_pkg::ACT_STOP: begin
            for (int i = 0; i < owpsc_pkg::WHEELS; i++) begin
               wheel_target[i] = 0; wheel_integ[i] = 0; wheel_prev_err[i] = 0;
            end
         end
         owpsc_pkg::ACT_TARGET: begin
            if (w < owpsc_pkg::WHEELS)
               wheel_target[w] = clip(longint'(c.target_speed), -vmax, vmax);
         end
         owpsc_pkg::ACT_BODY: begin
            rot = c2w * longint'(c.turn_rate) * 4;
            hx = longint'(c.velocity_x) * 32768;
            vys = longint'(c.velocity_y) * longint'(owpsc_pkg::HALF_SQRT3);
            ws[0] = hx - vys - rot;
            ws[1] = longint'(c.velocity_x) * 65536 + rot;
            ws[2] = hx + vys - rot;
            for (int i = 0; i < owpsc_pkg::WHEELS; i++)
               wheel_target[i] = clip(rnd_away(ws[i], 16), -vmax, vmax);
         end
         default: begin
            if (w < owpsc_pkg::WHEELS) begin
               t = wheel_target[w];
               rev = rev_mask[w];
               d = '0;
               d.drive_wheel = 2'(w);
               if (t >= -4 && t <= 4) begin
                  wheel_integ[w] = 0; wheel_prev_err[w] = 0;
               end else begin
                  spd = longint'(c.enc_pulses) * spp;
                  if (rev) spd = -spd;
                  spd = rnd_away(spd, 4);
                  err = clip(t - spd, -131072, 131071);
                  inc = rnd_away(err * 167772, 16);
                  integ = clip(wheel_integ[w] + inc, -83886, 83886);
                  wheel_integ[w] = integ;
                  deriv = (err - wheel_prev_err[w]) * 100;
                  wheel_prev_err[w] = err;
                  eff = kp * err * 256 + ki * integ + kd * deriv * 256 + t * 65536;
                  eff = rnd_away(eff, 16);
                  if ((t > 4 && eff < 0) || (t < -4 && eff > 0)) eff = 0;
                  eff = clip(eff, -vmax, vmax);
                  if (eff != 0) begin
                     pos = (eff > 0) != rev;
                     mag = eff < 0 ? -eff : eff;
                     dty = (mag * dscale + (64'sd1 <<< 19)) >>> 20;
                     if (dty > 16383) dty = 16383;
                     d.duty = 14'(dty);
                     d.dir_a = pos;
                     d.dir_b = !pos;
                  end
               end
               expected_drives.push_back(d);
            end
         end
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver
   initial begin
      req.valid = 1'b0; req.action = '0; req.wheel = '0; req.enc_pulses = '0;
      req.target_speed = '0; req.velocity_x = '0; req.velocity_y = '0; req.turn_rate = '0;
      rsp.ready = 1'b0;
   end

   int gap_left = 0;
   always @(posedge clock) begin
      command_type c;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            c = {req.action, req.wheel, req.enc_pulses, req.target_speed,
                 req.velocity_x, req.velocity_y, req.turn_rate};
            predict_drive(c);
         end
         if (!req.valid || req.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req.valid <= 1'b0;
            end else if (pending_commands.size() > 0) begin
               c = pending_commands.pop_front();
               {req.action, req.wheel, req.enc_pulses, req.target_speed,
                req.velocity_x, req.velocity_y, req.turn_rate} <= c;
               req.valid <= 1'b1;
               gap_left <= pick_gap();
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      drive_type a, e;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            a = {rsp.drive_wheel, rsp.duty, rsp.dir_a, rsp.dir_b};
            if (expected_drives.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %h", $time, a);
               errors++;
            end else begin
               e = expected_drives.pop_front();
               if (a.drive_wheel !== e.drive_wheel) begin
                  $display("%0t: drive_wheel expected %0d actual %0d", $time,
                           e.drive_wheel, a.drive_wheel);
                  errors++;
               end
               if (a.duty !== e.duty) begin
                  $display("%0t: duty expected %0d actual %0d", $time, e.duty, a.duty);
                  errors++;
               end
               if (a.dir_a !== e.dir_a) begin
                  $display("%0t: dir_a expected %0b actual %0b", $time, e.dir_a, a.dir_a);
                  errors++;
               end
               if (a.dir_b !== e.dir_b) begin
                  $display("%0t: dir_b expected %0b actual %0b", $time, e.dir_b, a.dir_b);
                  errors++;
               end
            end
         end
         if (stall_long > 0) begin
            stall_long <= stall_long - 1;
            rsp.ready <= 1'b0;
         end else if (rsp_flood) begin
            rsp_flood <= 1'b0;
            stall_long <= 200;
            rsp.ready <= 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0: begin
                  stall_long <= $urandom_range(5, 30);
                  rsp.ready <= 1'b0;
               end
               1, 2, 3: rsp.ready <= 1'b0;
               default: rsp.ready <= 1'b1;
            endcase
         end
      end
   end

   task automatic csr_write(owpsc_pkg::reg_index_type idx, longint value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[owpsc_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         owpsc_pkg::REG_GAIN_P:   kp = value & 16'hFFFF;
         owpsc_pkg::REG_GAIN_I:   ki = value & 16'hFFFF;
         owpsc_pkg::REG_GAIN_D:   kd = value & 16'hFFFF;
         owpsc_pkg::REG_SPP:      spp = value & 20'hFFFFF;
         owpsc_pkg::REG_MAX_SPD:  vmax = value & 15'h7FFF;
         owpsc_pkg::REG_DUTY_SCL: dscale = value & 24'hFFFFFF;
         owpsc_pkg::REG_REVERSED: rev_mask = value & 3'h7;
         owpsc_pkg::REG_CENTRE:   c2w = value & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_commands.size() > 0 || req.valid || expected_drives.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic command_type make_cmd(owpsc_pkg::action_type act, int w, int pc,
                                            int ts, int vx, int vy, int om);
      command_type c;
      c.action = act; c.wheel = 2'(w); c.enc_pulses = 16'(pc); c.target_speed = 16'(ts);
      c.velocity_x = 16'(vx); c.velocity_y = 16'(vy); c.turn_rate = 16'(om);
      return c;
   endfunction

   function automatic command_type random_cmd();
      command_type c;
      int r;
      c.enc_pulses = 16'(int'($urandom_range(0, 60000)) - 30000);
      if ($urandom_range(0, 3) != 0)
         c.enc_pulses = 16'(int'($urandom_range(0, 400)) - 200);
      c.target_speed = 16'($urandom);
      if ($urandom_range(0, 2) != 0)
         c.target_speed = 16'(int'($urandom_range(0, 16000)) - 8000);
      c.velocity_x = 16'($urandom); c.velocity_y = 16'($urandom);
      c.turn_rate = 16'($urandom);
      if ($urandom_range(0, 1)) begin
         c.velocity_x = 16'(int'($urandom_range(0, 8000)) - 4000);
         c.velocity_y = 16'(int'($urandom_range(0, 8000)) - 4000);
         c.turn_rate = 16'(int'($urandom_range(0, 4000)) - 2000);
      end
      c.wheel = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      c.action = r < 60 ? owpsc_pkg::ACT_TICK : r < 80 ? owpsc_pkg::ACT_TARGET :
                 r < 97 ? owpsc_pkg::ACT_BODY : owpsc_pkg::ACT_STOP;
      return c;
   endfunction

   task automatic random_cfg(bit extreme);
      csr_write(owpsc_pkg::REG_GAIN_P, extreme ? 65535 : $urandom_range(0, 1024));
      csr_write(owpsc_pkg::REG_GAIN_I, extreme ? 65535 : $urandom_range(0, 2048));
      csr_write(owpsc_pkg::REG_GAIN_D, extreme ? 0 : $urandom_range(0, 64));
      csr_write(owpsc_pkg::REG_SPP, extreme ? 1048575 : $urandom_range(0, 4000));
      csr_write(owpsc_pkg::REG_MAX_SPD, extreme ? 32767 : $urandom_range(1, 12000));
      csr_write(owpsc_pkg::REG_DUTY_SCL, extreme ? 16777215 : $urandom_range(0, 1200000));
      csr_write(owpsc_pkg::REG_REVERSED, $urandom_range(0, 7));
      csr_write(owpsc_pkg::REG_CENTRE, extreme ? 65535 : $urandom_range(0, 20000));
   endtask

   initial begin
      model_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed
      csr_write(owpsc_pkg::REG_DUTY_SCL, 400000);
      csr_write(owpsc_pkg::REG_SPP, 1000);
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TARGET, 0, 0, 32767, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TARGET, 1, 0, -32768, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TARGET, 2, 0, 4, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TARGET, 3, 0, 1000, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 3, 10, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 0, 30000, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 1, -30000, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 2, 5, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 0, -30000, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TARGET, 2, 0, -5, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 2, 0, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_BODY, 0, 0, 0, 32767, -32768,
                                          32767));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 1, 0, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_BODY, 0, 0, 0, -32768, 32767,
                                          -32768));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 0, 100, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_STOP, 0, 0, 0, 0, 0, 0));
      pending_commands.push_back(make_cmd(owpsc_pkg::ACT_TICK, 0, 100, 0, 0, 0, 0));
      drain();

      random_cfg(1'b1);
      for (int i = 0; i < 10; i++) pending_commands.push_back(random_cmd());
      drain();
      csr_write(owpsc_pkg::REG_MAX_SPD, 0);
      for (int i = 0; i < 10; i++) pending_commands.push_back(random_cmd());
      drain();

      // random phases; one with a long receiver hold-off
      for (int ph = 0; ph < 12; ph++) begin
         random_cfg(ph == 5);
         if (ph == 2) rsp_flood <= 1'b1;
         for (int i = 0; i < 100; i++) pending_commands.push_back(random_cmd());
         drain();
      end

      if (errors == 0 && expected_drives.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
